FILE: src/bpfa_pkg.sv
package bpfa_pkg;

	localparam int MAX_PAGES = 4096;
	localparam int CNT_W  = 13;
	localparam int PG_W   = 12;
	localparam int ACT_W  = 4;
	localparam int STAT_W = 3;

	localparam logic [ACT_W-1:0] ACT_ALLOC_ONE   = 4'd0;
	localparam logic [ACT_W-1:0] ACT_ALLOC_BELOW = 4'd1;
	localparam logic [ACT_W-1:0] ACT_ALLOC_RUN   = 4'd2;
	localparam logic [ACT_W-1:0] ACT_FREE_ONE    = 4'd3;
	localparam logic [ACT_W-1:0] ACT_FREE_RUN    = 4'd4;
	localparam logic [ACT_W-1:0] ACT_ADD_REF     = 4'd5;
	localparam logic [ACT_W-1:0] ACT_READ_REF    = 4'd6;
	localparam logic [ACT_W-1:0] ACT_RELEASE     = 4'd7;
	localparam logic [ACT_W-1:0] ACT_RESERVE     = 4'd8;

	localparam logic [STAT_W-1:0] STAT_OK        = 3'd0;
	localparam logic [STAT_W-1:0] STAT_NOSPACE   = 3'd1;
	localparam logic [STAT_W-1:0] STAT_RANGE     = 3'd2;
	localparam logic [STAT_W-1:0] STAT_UNMANAGED = 3'd3;
	localparam logic [STAT_W-1:0] STAT_DOUBLE    = 3'd4;

	typedef enum logic [2:0] {
		ST_CLR,
		ST_IDLE,
		ST_CHK,
		ST_STEP,
		ST_FILL,
		ST_REF,
		ST_OUT
	} bpfa_state_t;

endpackage

FILE: src/bitmap_page_frame_allocator.sv
// channel   direction  handshake              payload
// in        to block   in_valid / in_stall    action, page_number, page_count, below_limit
// out       from block out_valid / out_stall  status, result_page, ref_value, free_count,
//                                             usable_count
// cfg       to block   cfg_valid / cfg_ready  page_total
//
// alloc one / alloc below: the bitmap is scanned one 64-page word at a time
// alloc run: scans page by page for a free run, then goes back and takes it page by page
// free: checks every page, then counts each one down; release / reserve step page by page
// after reset a clearing pass over every bitmap word and reference count runs before the first request is taken
// a finished result waits in the output register while the next request is taken
module bitmap_page_frame_allocator
	import bpfa_pkg::*;
#(
	parameter int REF_WIDTH = 16
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 in_valid,
	output logic                 in_stall,
	input  logic [ACT_W-1:0]     action,
	input  logic [PG_W-1:0]      page_number,
	input  logic [CNT_W-1:0]     page_count,
	input  logic [CNT_W-1:0]     below_limit,
	output logic                 out_valid,
	input  logic                 out_stall,
	output logic [STAT_W-1:0]    status,
	output logic [PG_W-1:0]      result_page,
	output logic [REF_WIDTH-1:0] ref_value,
	output logic [CNT_W-1:0]     free_count,
	output logic [CNT_W-1:0]     usable_count,
	input  logic                 cfg_valid,
	output logic                 cfg_ready,
	input  logic [CNT_W-1:0]     page_total
);

	// bitmap words hold 64 pages each: managed bits on top, allocated bits below
	localparam int WORD = 64;
	localparam int WB   = $clog2(WORD);
	localparam int NW   = MAX_PAGES / WORD;
	localparam int WA   = (NW > 1) ? $clog2(NW) : 1;
	localparam int AW   = $clog2(MAX_PAGES);
	localparam int PW   = (AW + 1 > 14) ? AW + 1 : 14;
	localparam int USABLE_CAP = (MAX_PAGES < 8191) ? MAX_PAGES : 8191;
	localparam logic [REF_WIDTH-1:0] REF_MAX = '1;

	bpfa_state_t state_q, state_d;

	// memories
	logic [2*WORD-1:0]    bm_mem [NW];
	logic [REF_WIDTH-1:0] ref_mem [MAX_PAGES];
	logic [2*WORD-1:0]    bm_rdata_q, bm_wd;
	logic [REF_WIDTH-1:0] ref_rdata_q, ref_wd;
	logic                 bm_we, ref_we;
	logic [WA-1:0]        bm_wa, bm_ra;
	logic [AW-1:0]        ref_wa, ref_ra;

	// request and walk registers
	logic [ACT_W-1:0] act_q, act_d;
	logic [PW-1:0]    pg_q, pg_d, len_q, len_d, lim_q, lim_d;
	logic [PW-1:0]    p_q, p_d, end_q, end_d, start_q, start_d, run_q, run_d;
	logic             phase_q, phase_d;
	logic [AW:0]      clr_q, clr_d;

	// word cache in front of the bitmap memory, written back on a miss if dirty
	logic [WORD-1:0]  cw_man_q, cw_man_d, cw_alc_q, cw_alc_d;
	logic [WA-1:0]    cw_idx_q, cw_idx_d;
	logic             cw_vld_q, cw_vld_d, cw_dirty_q, cw_dirty_d;

	logic [CNT_W-1:0] free_q, free_d, usable_q, usable_d, ptot_q, ptot_d;

	// result of the current request
	logic [STAT_W-1:0]    res_st_q, res_st_d;
	logic [PW-1:0]        res_pg_q, res_pg_d;
	logic [REF_WIDTH-1:0] res_ref_q, res_ref_d;

	// output register
	logic                 out_valid_q, out_valid_d;
	logic [STAT_W-1:0]    out_st_q, out_st_d;
	logic [PG_W-1:0]      out_pg_q, out_pg_d;
	logic [REF_WIDTH-1:0] out_ref_q, out_ref_d;
	logic [CNT_W-1:0]     out_free_q, out_free_d, out_usable_q, out_usable_d;

	// events from the datapath to the sequencer
	logic ev_go, ev_clr_done, ev_fin, ev_miss, ev_ref, ev_back, ev_load;

	// helpers
	logic [PW-1:0]    tot, lim_e, st_now;
	logic [WA-1:0]    p_word;
	logic [WB-1:0]    b, k_idx, end_lo;
	logic             hit, pm, pa, rng_ok, same_word, k_found;
	logic [WORD-1:0]  fmask;

	assign tot    = (PW'(ptot_q) < PW'(MAX_PAGES)) ? PW'(ptot_q) : PW'(MAX_PAGES);
	assign lim_e  = (lim_q < tot) ? lim_q : tot;
	assign rng_ok = (len_q != '0) && (pg_q < tot) && (len_q <= tot - pg_q);
	assign p_word = p_q[WB +: WA];
	assign b      = p_q[WB-1:0];
	assign hit    = cw_vld_q && (cw_idx_q == p_word);
	assign pm     = cw_man_q[b];
	assign pa     = cw_alc_q[b];
	assign st_now = (run_q == '0) ? p_q : start_q;
	assign same_word = (end_q >> WB) == (p_q >> WB);
	assign end_lo = end_q[WB-1:0];

	// free pages of the cached word that lie below the search limit
	always_comb begin
		for (int i = 0; i < WORD; i++) begin
			fmask[i] = cw_man_q[i] & ~cw_alc_q[i] & (!same_word || (WB'(i) < end_lo));
		end
	end

	// lowest free page of the word
	always_comb begin
		k_idx   = '0;
		k_found = 1'b0;
		for (int i = WORD - 1; i >= 0; i--) begin
			if (fmask[i]) begin
				k_idx   = WB'(i);
				k_found = 1'b1;
			end
		end
	end

	assign bm_ra  = p_word;
	assign ref_ra = p_q[AW-1:0];

	// datapath
	always_comb begin
		act_d = act_q; pg_d = pg_q; len_d = len_q; lim_d = lim_q;
		p_d = p_q; end_d = end_q; start_d = start_q; run_d = run_q;
		phase_d = phase_q; clr_d = clr_q;
		cw_man_d = cw_man_q; cw_alc_d = cw_alc_q; cw_idx_d = cw_idx_q;
		cw_vld_d = cw_vld_q; cw_dirty_d = cw_dirty_q;
		free_d = free_q; usable_d = usable_q; ptot_d = ptot_q;
		res_st_d = res_st_q; res_pg_d = res_pg_q; res_ref_d = res_ref_q;
		out_valid_d = out_valid_q & out_stall;
		out_st_d = out_st_q; out_pg_d = out_pg_q; out_ref_d = out_ref_q;
		out_free_d = out_free_q; out_usable_d = out_usable_q;
		bm_we = 1'b0; bm_wa = cw_idx_q; bm_wd = {cw_man_q, cw_alc_q};
		ref_we = 1'b0; ref_wa = p_q[AW-1:0]; ref_wd = '0;
		ev_go = 1'b0; ev_clr_done = 1'b0; ev_fin = 1'b0; ev_miss = 1'b0;
		ev_ref = 1'b0; ev_back = 1'b0; ev_load = 1'b0;

		if (cfg_valid) begin
			ptot_d = page_total;
		end

		case (state_q)
			ST_CLR: begin
				// sweep: bitmap words to all ones, counts to zero
				bm_we  = clr_q < (AW + 1)'(NW);
				bm_wa  = clr_q[WA-1:0];
				bm_wd  = '1;
				ref_we = 1'b1;
				ref_wa = clr_q[AW-1:0];
				ref_wd = '0;
				clr_d  = clr_q + 1'b1;
				ev_clr_done = clr_q == (AW + 1)'(MAX_PAGES - 1);
			end
			ST_IDLE: begin
				if (in_valid) begin
					ev_go     = 1'b1;
					act_d     = action;
					pg_d      = PW'(page_number);
					len_d     = (action == ACT_FREE_ONE) ? PW'(1) : PW'(page_count);
					lim_d     = PW'(below_limit);
					phase_d   = 1'b0;
					run_d     = '0;
					res_st_d  = STAT_OK;
					res_pg_d  = '0;
					res_ref_d = '0;
				end
			end
			ST_CHK: begin
				p_d     = pg_q;
				start_d = pg_q;
				end_d   = pg_q + len_q;
				case (act_q)
					ACT_ALLOC_ONE, ACT_ALLOC_BELOW: begin
						p_d   = '0;
						end_d = (act_q == ACT_ALLOC_ONE) ? tot : lim_e;
						if (end_d == '0) begin
							ev_fin   = 1'b1;
							res_st_d = STAT_NOSPACE;
						end
					end
					ACT_ALLOC_RUN: begin
						p_d   = '0;
						end_d = tot;
						if (len_q == '0) begin
							ev_fin   = 1'b1;
							res_st_d = STAT_RANGE;
						end else if (len_q > tot) begin
							ev_fin   = 1'b1;
							res_st_d = STAT_NOSPACE;
						end
					end
					ACT_FREE_ONE, ACT_FREE_RUN, ACT_RELEASE, ACT_RESERVE: begin
						if (!rng_ok) begin
							ev_fin   = 1'b1;
							res_st_d = STAT_RANGE;
						end
					end
					ACT_ADD_REF, ACT_READ_REF: begin
						end_d = pg_q + PW'(1);
						if (pg_q >= tot) begin
							ev_fin   = 1'b1;
							res_st_d = STAT_RANGE;
						end
					end
					default: begin
						ev_fin   = 1'b1;
						res_st_d = STAT_RANGE;
					end
				endcase
			end
			ST_STEP: begin
				if (p_q >= end_q) begin
					// end of a pass
					case (act_q)
						ACT_ALLOC_ONE, ACT_ALLOC_BELOW: begin
							ev_fin   = 1'b1;
							res_st_d = STAT_NOSPACE;
						end
						ACT_ALLOC_RUN: begin
							ev_fin   = 1'b1;
							res_st_d = phase_q ? STAT_OK : STAT_NOSPACE;
							res_pg_d = phase_q ? start_q : '0;
						end
						ACT_FREE_ONE, ACT_FREE_RUN: begin
							if (phase_q) begin
								ev_fin = 1'b1;
							end else begin
								phase_d = 1'b1;
								p_d     = start_q;
							end
						end
						default: begin
							ev_fin = 1'b1;
						end
					endcase
				end else if (!hit) begin
					// write back the old word, fetch the new one
					ev_miss = 1'b1;
					bm_we   = cw_vld_q && cw_dirty_q;
				end else begin
					case (act_q)
						ACT_ALLOC_ONE, ACT_ALLOC_BELOW: begin
							if (k_found) begin
								cw_alc_d[k_idx] = 1'b1;
								cw_dirty_d = 1'b1;
								ref_we     = 1'b1;
								ref_wa     = p_q[AW-1:0] + AW'(k_idx);
								ref_wd     = REF_WIDTH'(1);
								free_d     = free_q - 1'b1;
								res_pg_d   = p_q + PW'(k_idx);
								ev_fin     = 1'b1;
							end else begin
								p_d = p_q + PW'(WORD);
							end
						end
						ACT_ALLOC_RUN: begin
							if (phase_q) begin
								cw_alc_d[b] = 1'b1;
								cw_dirty_d  = 1'b1;
								ref_we      = 1'b1;
								ref_wd      = REF_WIDTH'(1);
								free_d      = free_q - 1'b1;
								p_d         = p_q + 1'b1;
							end else if (pm && !pa) begin
								start_d = st_now;
								run_d   = run_q + 1'b1;
								p_d     = p_q + 1'b1;
								if (run_q + 1'b1 == len_q) begin
									// run found, go back and take it
									phase_d = 1'b1;
									p_d     = st_now;
									end_d   = st_now + len_q;
								end
							end else begin
								run_d = '0;
								p_d   = p_q + 1'b1;
							end
						end
						ACT_FREE_ONE, ACT_FREE_RUN: begin
							if (phase_q) begin
								ev_ref = 1'b1;
							end else if (!pm) begin
								ev_fin   = 1'b1;
								res_st_d = STAT_UNMANAGED;
							end else if (!pa) begin
								ev_fin   = 1'b1;
								res_st_d = STAT_DOUBLE;
							end else begin
								p_d = p_q + 1'b1;
							end
						end
						ACT_RELEASE: begin
							if (pa) begin
								cw_man_d[b] = 1'b1;
								cw_alc_d[b] = 1'b0;
								cw_dirty_d  = 1'b1;
								free_d      = free_q + 1'b1;
							end
							if (usable_q < CNT_W'(USABLE_CAP)) begin
								usable_d = usable_q + 1'b1;
							end
							p_d = p_q + 1'b1;
						end
						ACT_RESERVE: begin
							if (!pa) begin
								free_d = free_q - 1'b1;
							end
							cw_man_d[b] = 1'b0;
							cw_alc_d[b] = 1'b1;
							cw_dirty_d  = 1'b1;
							p_d         = p_q + 1'b1;
						end
						default: begin
							// add ref and read ref
							if (!pm) begin
								ev_fin   = 1'b1;
								res_st_d = STAT_UNMANAGED;
							end else begin
								ev_ref = 1'b1;
							end
						end
					endcase
				end
			end
			ST_FILL: begin
				cw_man_d   = bm_rdata_q[2*WORD-1:WORD];
				cw_alc_d   = bm_rdata_q[WORD-1:0];
				cw_idx_d   = p_word;
				cw_vld_d   = 1'b1;
				cw_dirty_d = 1'b0;
			end
			ST_REF: begin
				case (act_q)
					ACT_ADD_REF: begin
						ref_we = ref_rdata_q != REF_MAX;
						ref_wd = ref_rdata_q + 1'b1;
						ev_fin = 1'b1;
					end
					ACT_READ_REF: begin
						res_ref_d = ref_rdata_q;
						ev_fin    = 1'b1;
					end
					default: begin
						// free: count down, page goes free at zero
						ref_we  = 1'b1;
						ref_wd  = (ref_rdata_q != '0) ? ref_rdata_q - 1'b1 : ref_rdata_q;
						if (ref_wd == '0) begin
							cw_alc_d[b] = 1'b0;
							cw_dirty_d  = 1'b1;
							free_d      = free_q + 1'b1;
						end
						p_d     = p_q + 1'b1;
						ev_back = 1'b1;
					end
				endcase
			end
			ST_OUT: begin
				if (!out_valid_q || !out_stall) begin
					ev_load      = 1'b1;
					out_valid_d  = 1'b1;
					out_st_d     = res_st_q;
					out_pg_d     = res_pg_q[PG_W-1:0];
					out_ref_d    = res_ref_q;
					out_free_d   = free_q;
					out_usable_d = usable_q;
				end
			end
			default: begin
			end
		endcase
	end

	// sequencer
	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_CLR:  if (ev_clr_done) state_d = ST_IDLE;
			ST_IDLE: if (ev_go) state_d = ST_CHK;
			ST_CHK:  state_d = ev_fin ? ST_OUT : ST_STEP;
			ST_STEP: begin
				if (ev_fin) begin
					state_d = ST_OUT;
				end else if (ev_miss) begin
					state_d = ST_FILL;
				end else if (ev_ref) begin
					state_d = ST_REF;
				end
			end
			ST_FILL: state_d = ST_STEP;
			ST_REF: begin
				if (ev_fin) begin
					state_d = ST_OUT;
				end else if (ev_back) begin
					state_d = ST_STEP;
				end
			end
			ST_OUT:  if (ev_load) state_d = ST_IDLE;
			default: state_d = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_CLR;
			clr_q       <= '0;
			cw_vld_q    <= 1'b0;
			cw_dirty_q  <= 1'b0;
			free_q      <= '0;
			usable_q    <= '0;
			ptot_q      <= CNT_W'(4096);
			out_valid_q <= 1'b0;
			phase_q     <= 1'b0;
		end else begin
			state_q     <= state_d;
			clr_q       <= clr_d;
			cw_vld_q    <= cw_vld_d;
			cw_dirty_q  <= cw_dirty_d;
			free_q      <= free_d;
			usable_q    <= usable_d;
			ptot_q      <= ptot_d;
			out_valid_q <= out_valid_d;
			phase_q     <= phase_d;
		end
	end

	always_ff @(posedge clk) begin
		act_q <= act_d; pg_q <= pg_d; len_q <= len_d; lim_q <= lim_d;
		p_q <= p_d; end_q <= end_d; start_q <= start_d; run_q <= run_d;
		cw_man_q <= cw_man_d; cw_alc_q <= cw_alc_d; cw_idx_q <= cw_idx_d;
		res_st_q <= res_st_d; res_pg_q <= res_pg_d; res_ref_q <= res_ref_d;
		out_st_q <= out_st_d; out_pg_q <= out_pg_d; out_ref_q <= out_ref_d;
		out_free_q <= out_free_d; out_usable_q <= out_usable_d;
	end

	// bitmap memory, one write and one registered read per cycle
	always_ff @(posedge clk) begin
		if (bm_we) begin
			bm_mem[bm_wa] <= bm_wd;
		end
		bm_rdata_q <= bm_mem[bm_ra];
	end

	// reference count memory
	always_ff @(posedge clk) begin
		if (ref_we) begin
			ref_mem[ref_wa] <= ref_wd;
		end
		ref_rdata_q <= ref_mem[ref_ra];
	end

	assign in_stall     = state_q != ST_IDLE;
	assign cfg_ready    = 1'b1;
	assign out_valid    = out_valid_q;
	assign status       = out_st_q;
	assign result_page  = out_pg_q;
	assign ref_value    = out_ref_q;
	assign free_count   = out_free_q;
	assign usable_count = out_usable_q;

endmodule
